FILE: hdl/trd_pkg.sv
// Shared types and constants for the TLS record deframer.
package trd_pkg;

   localparam logic [7:0]  TYPE_LOW      = 8'd20;
   localparam logic [7:0]  TYPE_HIGH     = 8'd23;
   localparam logic [15:0] MAX_LEN_RESET = 16'd18432;

   typedef enum logic [2:0] {
      ST_TYPE,
      ST_VER_HI,
      ST_VER_LO,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_PAYLOAD
   } rec_state_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_TYPE = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;

endpackage

FILE: hdl/tls_record_deframer.sv
// TLS record deframer: header parse, checks and payload and status beat output.
//
//  channel  | ports                              | direction
//  ---------+------------------------------------+----------
//  request  | req_valid req_ready req_data_byte  | in
//  response | rsp_valid rsp_ready rsp_record_*   | out
//           | rsp_payload_byte rsp_has_byte      |
//           | rsp_last rsp_status                |
//  csr      | csr_wr_en csr_wr_data              | in
//
// One request beat per cycle while req_ready is high; its response, if any,
// comes out of the single response register in the following cycle. req_ready
// drops only while the response register holds a beat that is not taken.
// Synchronous reset clears the parser, the failure flag and the maximum length
// (to 18432). After a failure every beat is taken and dropped until reset.
module tls_record_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_record_type,
   output logic [15:0] rsp_record_version,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_has_byte,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import trd_pkg::*;

   rec_state_type state_ff, state_in, cur_st;
   logic [7:0]  held_type_ff, held_type_in;
   logic [15:0] held_version_ff, held_version_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic        failed_ff, failed_in;
   logic [15:0] max_len_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_type_ff;
   logic [15:0] rsp_version_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_has_ff;
   logic        rsp_last_ff;
   status_type  rsp_status_ff;

   logic        accept;
   logic        load;
   logic [15:0] len;
   logic        type_bad;
   logic        len_bad;

   logic        res_valid;
   logic [7:0]  res_byte;
   logic        res_has;
   logic        res_last;
   status_type  res_status;

   assign load      = !rsp_valid_ff || rsp_ready;
   assign req_ready = load;
   assign accept    = req_valid && req_ready;

   assign len      = {length_high_ff, req_data_byte};
   assign type_bad = (held_type_ff < TYPE_LOW) || (held_type_ff > TYPE_HIGH);
   assign len_bad  = len > max_len_ff;
   assign cur_st   = (state_ff == ST_PAYLOAD && bytes_left_ff == 16'd0) ? ST_TYPE
                                                                         : state_ff;

   // next state
   always_comb begin
      state_in        = state_ff;
      held_type_in    = held_type_ff;
      held_version_in = held_version_ff;
      length_high_in  = length_high_ff;
      bytes_left_in   = bytes_left_ff;
      failed_in       = failed_ff;
      if (accept && !failed_ff) begin
         unique case (cur_st)
            ST_TYPE: begin
               held_type_in = req_data_byte;
               state_in     = ST_VER_HI;
            end
            ST_VER_HI: begin
               held_version_in = {req_data_byte, 8'h00};
               state_in        = ST_VER_LO;
            end
            ST_VER_LO: begin
               held_version_in = {held_version_ff[15:8], req_data_byte};
               state_in        = ST_LEN_HI;
            end
            ST_LEN_HI: begin
               length_high_in = req_data_byte;
               state_in       = ST_LEN_LO;
            end
            ST_LEN_LO: begin
               if (type_bad || len_bad) begin
                  failed_in = 1'b1;
                  state_in  = ST_TYPE;
               end else if (len == 16'd0) begin
                  bytes_left_in = 16'd0;
                  state_in      = ST_TYPE;
               end else begin
                  bytes_left_in = len;
                  state_in      = ST_PAYLOAD;
               end
            end
            ST_PAYLOAD: begin
               bytes_left_in = bytes_left_ff - 16'd1;
               if (bytes_left_ff == 16'd1) begin
                  state_in = ST_TYPE;
               end
            end
            default: begin
               state_in = ST_TYPE;
            end
         endcase
      end
   end

   // result beat
   always_comb begin
      res_valid  = 1'b0;
      res_byte   = 8'h00;
      res_has    = 1'b0;
      res_last   = 1'b0;
      res_status = STATUS_OK;
      if (accept && !failed_ff) begin
         unique case (cur_st)
            ST_LEN_LO: begin
               priority if (type_bad) begin
                  res_valid  = 1'b1;
                  res_status = STATUS_BAD_TYPE;
               end else if (len_bad) begin
                  res_valid  = 1'b1;
                  res_status = STATUS_TOO_LONG;
               end else if (len == 16'd0) begin
                  res_valid = 1'b1;
                  res_last  = 1'b1;
               end else begin
                  res_valid = 1'b0;
               end
            end
            ST_PAYLOAD: begin
               res_valid = 1'b1;
               res_byte  = req_data_byte;
               res_has   = 1'b1;
               res_last  = (bytes_left_ff == 16'd1);
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_TYPE;
         held_type_ff    <= 8'h00;
         held_version_ff <= 16'h0000;
         length_high_ff  <= 8'h00;
         bytes_left_ff   <= 16'h0000;
         failed_ff       <= 1'b0;
         max_len_ff      <= MAX_LEN_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         held_type_ff    <= held_type_in;
         held_version_ff <= held_version_in;
         length_high_ff  <= length_high_in;
         bytes_left_ff   <= bytes_left_in;
         failed_ff       <= failed_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (load) begin
            rsp_valid_ff <= res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && res_valid) begin
         rsp_type_ff    <= held_type_ff;
         rsp_version_ff <= held_version_ff;
         rsp_byte_ff    <= res_byte;
         rsp_has_ff     <= res_has;
         rsp_last_ff    <= res_last;
         rsp_status_ff  <= res_status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_record_type    = rsp_type_ff;
   assign rsp_record_version = rsp_version_ff;
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_has_byte       = rsp_has_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef SYNTHESIS
   a_failed_silent: assert property (@(posedge clock) disable iff (reset)
      failed_ff && load |=> !rsp_valid_ff)
      else $error("beat produced after framing failure");

   a_failed_parked: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> state_ff == ST_TYPE)
      else $error("parser not parked after failure");

   a_payload_due: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAYLOAD |-> bytes_left_ff != 16'd0)
      else $error("payload phase with no bytes due");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |-> !rsp_has_ff && !rsp_last_ff)
      else $error("error beat carries data or last");
`endif

endmodule
